>>> design/rwsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_pkg: shared types and constants for the reno window sender control
// Widths, reset values, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rwsc_pkg;

   // field widths
   localparam int SEQ_W     = 16;
   localparam int CFG_W     = 16;
   localparam int WIN_W     = 7;
   localparam int TICK_W    = 32;
   localparam int DUP_W     = 2;
   localparam int CSR_IDX_W = 2;

   // window and run limits
   localparam int MAX_WINDOW = 64;
   localparam int MAX_RUN    = 64;
   localparam int RUN_W      = $clog2(MAX_RUN + 1);

   // send-time ring, one entry per sequence number modulo the depth
   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] RST_TOTAL_PACKETS = CFG_W'(0);
   localparam logic [CFG_W-1:0] RST_INIT_THRESH   = CFG_W'(20);
   localparam logic [CFG_W-1:0] RST_TIMEOUT_TICKS = CFG_W'(500);

   // fast recovery window bonus and duplicate ack level
   localparam int               TIMEOUT_BONUS = 3;
   localparam logic [DUP_W-1:0] DUP_MAX       = DUP_W'(3);

   // input opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_THRESHOLD = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS     = CSR_IDX_W'(2);

   typedef struct packed {
      logic capture;
      logic tick_inc;
      logic ack_update;
      logic check;
      logic start_resend;
      logic start_send;
      logic emit_run;
      logic emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
      logic timed_out;
      logic send_none;
      logic run_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/rwsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rwsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_ctrl: sequencing state machine
// Accepts one beat at a time and steps the datapath through ack update,
// timer check, send/resend runs and the single status beat.
// ----------------------------------------------------------------------------
module rwsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  rwsc_pkg::dp_status_type status,
   output rwsc_pkg::dp_cmd_type    cmd
);

   import rwsc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_CHECK,
      ST_DECIDE,
      ST_RUN,
      ST_STATUS
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_opcode == OP_TICK) begin
                  cmd.tick_inc = 1'b1;
                  state_in     = ST_CHECK;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            cmd.ack_update = 1'b1;
            state_in       = ST_STATUS;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (status.finished) begin
               state_in = ST_STATUS;
            end else if (status.timed_out) begin
               cmd.start_resend = 1'b1;
               state_in         = ST_RUN;
            end else begin
               cmd.start_send = 1'b1;
               state_in       = status.send_none ? ST_STATUS : ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               cmd.emit_run = 1'b1;
               if (status.run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // the last beat of a run hands control back to idle
   a_run_end_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_run && status.run_last) |=> (state_ff == ST_IDLE))
      else $error("run did not end in idle");

   a_capture_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_valid && !req_stall))
      else $error("capture without an accepted beat");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_run && cmd.emit_status))
      else $error("run and status beat emitted together");

endmodule

>>> design/rwsc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_dpath: window, congestion and timer datapath
// Holds the configuration registers, sliding window state, timer ring and
// the result output register.
// ----------------------------------------------------------------------------
module rwsc_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  rwsc_pkg::dp_cmd_type              cmd,
   output rwsc_pkg::dp_status_type           status,
   input  logic [rwsc_pkg::SEQ_W-1:0]        req_ack_number,
   input  logic                              req_ack_flag,
   input  logic                              req_nak_flag,
   input  logic                              csr_write_en,
   input  logic [rwsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rwsc_pkg::CFG_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_send_valid,
   output logic [rwsc_pkg::SEQ_W-1:0]        rsp_packet_seq,
   output logic                              rsp_is_resend,
   output logic [rwsc_pkg::WIN_W-1:0]        rsp_window_now,
   output logic                              rsp_transfer_done,
   output logic                              rsp_last_of_run
);

   import rwsc_pkg::*;

   localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);
   localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);

   // configuration
   logic [CFG_W-1:0]      total_ff, total_in;
   logic [CFG_W-1:0]      init_thr_ff, init_thr_in;
   logic [CFG_W-1:0]      cfg_timeout_ff, cfg_timeout_in;

   // window and congestion state
   logic [SEQ_W-1:0]      base_ff, base_in;
   logic [SEQ_W-1:0]      next_ff, next_in;
   logic [WIN_W-1:0]      cw_ff, cw_in;
   logic [SEQ_W-1:0]      thr_ff, thr_in;
   logic [SEQ_W-1:0]      prev_ack_ff, prev_ack_in;
   logic [DUP_W-1:0]      dup_ff, dup_in;
   logic                  dup_seen_ff, dup_seen_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [RING_DEPTH-1:0] armed_ff, armed_in;

   // captured ack beat
   logic [SEQ_W-1:0]      ack_num_ff, ack_num_in;
   logic                  ack_flag_ff, ack_flag_in;
   logic                  nak_flag_ff, nak_flag_in;

   // timer check and run
   logic                  timed_out_ff, timed_out_in;
   logic [SEQ_W-1:0]      run_seq_ff, run_seq_in;
   logic [RUN_W-1:0]      run_left_ff, run_left_in;
   logic                  run_resend_ff, run_resend_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_send_ff, out_send_in;
   logic [SEQ_W-1:0]      out_seq_ff, out_seq_in;
   logic                  out_resend_ff, out_resend_in;
   logic [WIN_W-1:0]      out_win_ff, out_win_in;
   logic                  out_done_ff, out_done_in;
   logic                  out_last_ff, out_last_in;

   // combinational helpers
   logic [RING_AW-1:0]    base_idx;
   logic [RING_AW-1:0]    run_idx;
   logic [TICK_W-1:0]     send_time;
   logic [TICK_W-1:0]     age;
   logic                  finished;
   logic                  base_lt_next;
   logic [SEQ_W-1:0]      gap;
   logic [SEQ_W-1:0]      avail;
   logic [WIN_W-1:0]      room;
   logic [RUN_W-1:0]      send_cnt;
   logic [RUN_W-1:0]      resend_cnt;
   logic [SEQ_W-1:0]      thr_half;
   logic [SEQ_W:0]        thr_bonus;
   logic [WIN_W-1:0]      cw_timeout;
   logic [SEQ_W:0]        ack_ext;
   logic [SEQ_W:0]        base_p1;
   logic                  in_order;
   logic                  jump;
   logic [SEQ_W-1:0]      base_inc;
   logic [WIN_W:0]        cw_dbl;
   logic [WIN_W:0]        cw_inc;
   logic [WIN_W-1:0]      cw_grow;
   logic [SEQ_W-1:0]      nb_raw;
   logic [SEQ_W-1:0]      nb;
   logic                  jump_take;

   rwsc_ram #(
      .WIDTH (TICK_W),
      .DEPTH (RING_DEPTH)
   ) u_send_time (
      .clock   (clock),
      .wr_en   (cmd.emit_run),
      .wr_addr (run_idx),
      .wr_data (tick_ff),
      .rd_addr (base_idx),
      .rd_data (send_time)
   );

   assign base_idx     = base_ff[RING_AW-1:0];
   assign run_idx      = run_seq_ff[RING_AW-1:0];
   assign finished     = (base_ff >= total_ff);
   assign base_lt_next = (base_ff < next_ff);
   assign gap          = next_ff - base_ff;
   assign age          = tick_ff - send_time;

   // new sends: limited by packets left and by room in the window
   always_comb begin
      avail = (next_ff < total_ff) ? (total_ff - next_ff) : '0;
      if (!base_lt_next && (gap == '0)) begin
         room = cw_ff;
      end else if (base_lt_next && (gap < SEQ_W'(cw_ff))) begin
         room = cw_ff - gap[WIN_W-1:0];
      end else begin
         room = '0;
      end
      if (avail < SEQ_W'(room)) begin
         send_cnt = avail[RUN_W-1:0];
      end else begin
         send_cnt = RUN_W'(room);
      end
      resend_cnt = (gap > SEQ_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : gap[RUN_W-1:0];
   end

   // timeout: halve threshold, fast recovery window after duplicate acks
   assign thr_half   = {1'b0, thr_ff[SEQ_W-1:1]};
   assign thr_bonus  = {1'b0, thr_half} + (SEQ_W+1)'(TIMEOUT_BONUS);
   assign cw_timeout = !dup_seen_ff ? WIN_ONE :
                       (thr_bonus > (SEQ_W+1)'(MAX_WINDOW)) ? WIN_MAX :
                       thr_bonus[WIN_W-1:0];

   // ack decode, compared one bit wider so base+1 cannot wrap
   assign ack_ext   = {1'b0, ack_num_ff};
   assign base_p1   = {1'b0, base_ff} + (SEQ_W+1)'(1);
   assign in_order  = ack_flag_ff && !nak_flag_ff && (ack_ext == base_p1);
   assign jump      = !in_order && (ack_ext > base_p1);
   assign base_inc  = base_ff + SEQ_W'(1);
   assign cw_dbl    = {cw_ff, 1'b0};
   assign cw_inc    = {1'b0, cw_ff} + (WIN_W+1)'(1);
   assign nb_raw    = ack_num_ff - SEQ_W'(1);
   assign nb        = (nb_raw > total_ff) ? total_ff : nb_raw;
   assign jump_take = jump && (nb > base_ff);

   always_comb begin
      if (SEQ_W'(cw_ff) <= thr_ff) begin
         cw_grow = (cw_dbl > (WIN_W+1)'(MAX_WINDOW)) ? WIN_MAX : cw_dbl[WIN_W-1:0];
      end else begin
         cw_grow = (cw_inc > (WIN_W+1)'(MAX_WINDOW)) ? WIN_MAX : cw_inc[WIN_W-1:0];
      end
   end

   always_comb begin
      total_in       = total_ff;
      init_thr_in    = init_thr_ff;
      cfg_timeout_in = cfg_timeout_ff;
      base_in        = base_ff;
      next_in        = next_ff;
      cw_in          = cw_ff;
      thr_in         = thr_ff;
      prev_ack_in    = prev_ack_ff;
      dup_in         = dup_ff;
      dup_seen_in    = dup_seen_ff;
      tick_in        = tick_ff;
      armed_in       = armed_ff;
      ack_num_in     = ack_num_ff;
      ack_flag_in    = ack_flag_ff;
      nak_flag_in    = nak_flag_ff;
      timed_out_in   = timed_out_ff;
      run_seq_in     = run_seq_ff;
      run_left_in    = run_left_ff;
      run_resend_in  = run_resend_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TOTAL_PACKETS: begin
               total_in = csr_wdata;
            end
            CSR_INITIAL_THRESHOLD: begin
               init_thr_in = csr_wdata;
               // threshold follows the register until the first send
               if (next_ff == '0) begin
                  thr_in = csr_wdata;
               end
            end
            CSR_TIMEOUT_TICKS: begin
               cfg_timeout_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         ack_num_in  = req_ack_number;
         ack_flag_in = req_ack_flag;
         nak_flag_in = req_nak_flag;
      end

      if (cmd.tick_inc) begin
         tick_in = tick_ff + TICK_W'(1);
      end

      if (cmd.check) begin
         timed_out_in = armed_ff[base_idx] && base_lt_next &&
                        (age > TICK_W'(cfg_timeout_ff));
      end

      if (cmd.ack_update) begin
         if (in_order) begin
            if (finished == 1'b0) begin
               armed_in[base_idx] = 1'b0;
               base_in            = base_inc;
               if (base_inc < total_ff) begin
                  cw_in = cw_grow;
               end
            end
         end else if (jump_take) begin
            base_in                      = nb;
            armed_in[nb[RING_AW-1:0]]    = 1'b0;
            if (next_ff < nb) begin
               next_in = nb;
            end
         end
         if (prev_ack_ff != ack_num_ff) begin
            dup_in      = '0;
            prev_ack_in = ack_num_ff;
            dup_seen_in = 1'b0;
         end else begin
            if (dup_ff < DUP_MAX) begin
               dup_in = dup_ff + DUP_W'(1);
            end
            if (dup_in == DUP_MAX) begin
               dup_seen_in = 1'b1;
            end
         end
      end

      if (cmd.start_resend) begin
         thr_in        = thr_half;
         cw_in         = cw_timeout;
         run_seq_in    = base_ff;
         run_left_in   = resend_cnt;
         run_resend_in = 1'b1;
      end

      if (cmd.start_send) begin
         run_seq_in    = next_ff;
         run_left_in   = send_cnt;
         run_resend_in = 1'b0;
      end

      if (cmd.emit_run) begin
         armed_in[run_idx] = 1'b1;
         run_seq_in        = run_seq_ff + SEQ_W'(1);
         run_left_in       = run_left_ff - RUN_W'(1);
         if (!run_resend_ff) begin
            next_in = next_ff + SEQ_W'(1);
         end
      end
   end

   // output register: refilled when empty or when its beat is taken
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_send_in   = out_send_ff;
      out_seq_in    = out_seq_ff;
      out_resend_in = out_resend_ff;
      out_win_in    = out_win_ff;
      out_done_in   = out_done_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit_run) begin
         out_valid_in  = 1'b1;
         out_send_in   = 1'b1;
         out_seq_in    = run_seq_ff;
         out_resend_in = run_resend_ff;
         out_win_in    = cw_ff;
         out_done_in   = finished;
         out_last_in   = (run_left_ff == RUN_W'(1));
      end else if (cmd.emit_status) begin
         out_valid_in  = 1'b1;
         out_send_in   = 1'b0;
         out_seq_in    = '0;
         out_resend_in = 1'b0;
         out_win_in    = cw_ff;
         out_done_in   = finished;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= RST_TOTAL_PACKETS;
         init_thr_ff    <= RST_INIT_THRESH;
         cfg_timeout_ff <= RST_TIMEOUT_TICKS;
         base_ff        <= '0;
         next_ff        <= '0;
         cw_ff          <= WIN_ONE;
         thr_ff         <= RST_INIT_THRESH;
         prev_ack_ff    <= '0;
         dup_ff         <= '0;
         dup_seen_ff    <= 1'b0;
         tick_ff        <= '0;
         armed_ff       <= '0;
         timed_out_ff   <= 1'b0;
         run_left_ff    <= '0;
         run_resend_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         total_ff       <= total_in;
         init_thr_ff    <= init_thr_in;
         cfg_timeout_ff <= cfg_timeout_in;
         base_ff        <= base_in;
         next_ff        <= next_in;
         cw_ff          <= cw_in;
         thr_ff         <= thr_in;
         prev_ack_ff    <= prev_ack_in;
         dup_ff         <= dup_in;
         dup_seen_ff    <= dup_seen_in;
         tick_ff        <= tick_in;
         armed_ff       <= armed_in;
         timed_out_ff   <= timed_out_in;
         run_left_ff    <= run_left_in;
         run_resend_ff  <= run_resend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_num_ff    <= ack_num_in;
      ack_flag_ff   <= ack_flag_in;
      nak_flag_ff   <= nak_flag_in;
      run_seq_ff    <= run_seq_in;
      out_send_ff   <= out_send_in;
      out_seq_ff    <= out_seq_in;
      out_resend_ff <= out_resend_in;
      out_win_ff    <= out_win_in;
      out_done_ff   <= out_done_in;
      out_last_ff   <= out_last_in;
   end

   assign status.finished  = finished;
   assign status.timed_out = timed_out_ff;
   assign status.send_none = (send_cnt == '0);
   assign status.run_last  = (run_left_ff == RUN_W'(1));
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_send_valid    = out_send_ff;
   assign rsp_packet_seq    = out_seq_ff;
   assign rsp_is_resend     = out_resend_ff;
   assign rsp_window_now    = out_win_ff;
   assign rsp_transfer_done = out_done_ff;
   assign rsp_last_of_run   = out_last_ff;

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      (cw_ff >= WIN_ONE) && (cw_ff <= WIN_MAX))
      else $error("congestion window out of range");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_left_ff <= RUN_W'(MAX_RUN))
      else $error("run length above limit");

   // every packet sent or resent leaves its timer armed
   a_timer_armed: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_run |=> armed_ff[$past(run_idx)])
      else $error("timer not armed after send");

endmodule

>>> design/reno_window_sender_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_window_sender_control_unit: sliding window and congestion control
// Top level joining the sequencing controller and the window datapath.
// ----------------------------------------------------------------------------
// usage
//   req beats: opcode tick (time step with send opportunity) or ack (with
//   ack_number, ack_flag, nak_flag). a beat moves when req_valid is high and
//   req_stall low; req_stall is high while a beat is in work.
//   rsp beats: one per packet to send or resend, or one status beat with
//   send_valid low; last_of_run marks the final beat of each request.
//   csr port: csr_write_en writes csr_wdata to register csr_index (0 total
//   packets, 1 initial threshold, 2 timeout ticks); user must write only when idle, not enforced.
// timing
//   ack: ack update, then the status beat, then back to idle for the next accept.
//   tick: timer check, decide, then the result beats, one beat a cycle once the
//   send-time ring's registered read and the timeout compare are done.
//   a stalled rsp side holds the output register and pauses the run.
// reset
//   synchronous; window base 0, window 1, threshold 20, all timers disarmed.
// ----------------------------------------------------------------------------
module reno_window_sender_control_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [rwsc_pkg::SEQ_W-1:0]     req_ack_number,
   input  logic                           req_ack_flag,
   input  logic                           req_nak_flag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_send_valid,
   output logic [rwsc_pkg::SEQ_W-1:0]     rsp_packet_seq,
   output logic                           rsp_is_resend,
   output logic [rwsc_pkg::WIN_W-1:0]     rsp_window_now,
   output logic                           rsp_transfer_done,
   output logic                           rsp_last_of_run,
   input  logic                           csr_write_en,
   input  logic [rwsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rwsc_pkg::CFG_W-1:0]     csr_wdata
);

   import rwsc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rwsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   rwsc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_ack_number    (req_ack_number),
      .req_ack_flag      (req_ack_flag),
      .req_nak_flag      (req_nak_flag),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_packet_seq    (rsp_packet_seq),
      .rsp_is_resend     (rsp_is_resend),
      .rsp_window_now    (rsp_window_now),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

>>> tb/sv/reno_window_sender_control_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_window_sender_control_unit_tb: self-checking bench for the sender
// A predictor kept in step with every accepted req beat lists the rsp beats
// due. Directed beats cover the corner cases first. Random transfers follow,
// with mostly in-order acks plus duplicates, jumps and noise, while both
// sides stall at random and the settings change between phases.
// ----------------------------------------------------------------------------
module reno_window_sender_control_unit_tb;
   import rwsc_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 600000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 175;

   typedef struct packed {
      logic             send_valid;
      logic [SEQ_W-1:0] packet_seq;
      logic             is_resend;
      logic [WIN_W-1:0] window_now;
      logic             transfer_done;
      logic             last_of_run;
   } rsp_beat_type;

   class window_scoreboard_type;
      rsp_beat_type beats_due[$];
      rsp_beat_type run[$];
      int unsigned total_packets, init_threshold, timeout_ticks;
      int unsigned base, next_seq, cwnd, ssthresh, prev_ack, dup_count;
      bit dup_seen;
      int unsigned now;
      int unsigned sent_at[RING_DEPTH];
      bit armed[RING_DEPTH];
      int errors, n_ticks, n_acks, n_beats, n_new, n_resends, n_timeouts, longest_run;

      function new();
         total_packets  = RST_TOTAL_PACKETS;
         init_threshold = RST_INIT_THRESH;
         timeout_ticks  = RST_TIMEOUT_TICKS;
         base = 0;
         next_seq = 0;
         cwnd = 1;
         ssthresh = init_threshold;
         prev_ack = 0;
         dup_count = 0;
         dup_seen = 0;
         now = 0;
         foreach (armed[i]) begin
            armed[i] = 0;
            sent_at[i] = 0;
         end
         errors = 0;
         n_ticks = 0;
         n_acks = 0;
         n_beats = 0;
         n_new = 0;
         n_resends = 0;
         n_timeouts = 0;
         longest_run = 0;
      endfunction

      function int unsigned capped(int unsigned w);
         return (w > MAX_WINDOW) ? MAX_WINDOW : w;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_TOTAL_PACKETS: total_packets = val;
            CSR_INITIAL_THRESHOLD: begin
               init_threshold = val;
               // threshold only follows the register until the first send
               if (next_seq == 0) ssthresh = val;
            end
            CSR_TIMEOUT_TICKS: timeout_ticks = val;
            default: ;
         endcase
      endfunction

      function void list_packet(int unsigned seq, bit resend);
         rsp_beat_type b;
         b = '0;
         b.send_valid = 1'b1;
         b.packet_seq = SEQ_W'(seq);
         b.is_resend = resend;
         sent_at[seq % RING_DEPTH] = now;
         armed[seq % RING_DEPTH] = 1'b1;
         run = {run, b};
         if (resend) n_resends++;
         else n_new++;
      endfunction

      function void note_request(logic op, logic [SEQ_W-1:0] ack_number, logic ack_flag,
                                 logic nak_flag);
         rsp_beat_type b;
         int unsigned s, slot, nb;
         int k;
         run.delete();
         if (op == OP_TICK) begin
            n_ticks++;
            now++;
            slot = base % RING_DEPTH;
            if (base >= total_packets) begin
               // finished transfer: time moves on, nothing else
            end else if (base < next_seq && armed[slot] &&
                         (now - sent_at[slot]) > timeout_ticks) begin
               n_timeouts++;
               ssthresh = ssthresh >> 1;
               cwnd = dup_seen ? capped(ssthresh + TIMEOUT_BONUS) : 1;
               for (s = base; s < next_seq && run.size() < MAX_RUN; s++)
                  list_packet(s, 1'b1);
            end else begin
               // unsigned distance: nothing goes out while base is past next_seq
               while (next_seq < total_packets && next_seq - base < cwnd &&
                      run.size() < MAX_RUN) begin
                  list_packet(next_seq, 1'b0);
                  next_seq++;
               end
            end
         end else begin
            n_acks++;
            if (ack_flag && !nak_flag && ack_number == base + 1) begin
               if (base < total_packets) begin
                  armed[base % RING_DEPTH] = 1'b0;
                  base++;
                  if (base < total_packets) begin
                     if (cwnd <= ssthresh) cwnd = capped(cwnd * 2);
                     else cwnd = capped(cwnd + 1);
                  end
               end
            end else if (ack_number > base + 1) begin
               nb = ack_number - 1;
               if (nb > total_packets) nb = total_packets;
               if (nb > base) begin
                  base = nb;
                  armed[base % RING_DEPTH] = 1'b0;
                  if (next_seq < base) next_seq = base;
               end
            end
            if (prev_ack != ack_number) begin
               dup_count = 0;
               prev_ack = ack_number;
               dup_seen = 0;
            end else begin
               if (dup_count < DUP_MAX) dup_count++;
               if (dup_count > 2) dup_seen = 1;
            end
         end
         if (run.size() == 0) begin
            b = '0;
            run = {run, b};
         end
         if (run.size() > longest_run) longest_run = run.size();
         for (k = 0; k < run.size(); k++) begin
            b = run[k];
            b.window_now = WIN_W'(cwnd);
            b.transfer_done = (base >= total_packets);
            b.last_of_run = (k == run.size() - 1);
            beats_due = {beats_due, b};
         end
      endfunction

      function void compare_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         n_beats++;
         if (beats_due.size() == 0) begin
            errors++;
            $error("rsp beat with nothing due: send_valid %0b seq %0d",
                   got.send_valid, got.packet_seq);
            return;
         end
         want = beats_due.pop_front();
         compare_field("send_valid", want.send_valid, got.send_valid);
         compare_field("packet_seq", want.packet_seq, got.packet_seq);
         compare_field("is_resend", want.is_resend, got.is_resend);
         compare_field("window_now", want.window_now, got.window_now);
         compare_field("transfer_done", want.transfer_done, got.transfer_done);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic [SEQ_W-1:0]     req_ack_number;
   logic                 req_ack_flag;
   logic                 req_nak_flag;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_send_valid;
   logic [SEQ_W-1:0]     rsp_packet_seq;
   logic                 rsp_is_resend;
   logic [WIN_W-1:0]     rsp_window_now;
   logic                 rsp_transfer_done;
   logic                 rsp_last_of_run;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   window_scoreboard_type sb;
   bit quiet;
   bit hold_req;
   int items_sent;
   int phases;

   reno_window_sender_control_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_ack_number    (req_ack_number),
      .req_ack_flag      (req_ack_flag),
      .req_nak_flag      (req_nak_flag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_packet_seq    (rsp_packet_seq),
      .rsp_is_resend     (rsp_is_resend),
      .rsp_window_now    (rsp_window_now),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_beat({rsp_send_valid, rsp_packet_seq, rsp_is_resend, rsp_window_now,
                        rsp_transfer_done, rsp_last_of_run});
   end

   initial begin : rsp_pacing
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            // long hold-off so the output side backs up into req_stall
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) < 2) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $error("watchdog expired with %0d rsp beats still due", sb.beats_due.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic send_req(logic op, logic [SEQ_W-1:0] an, logic af, logic nf);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_ack_number <= an;
      req_ack_flag <= af;
      req_nak_flag <= nf;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, an, af, nf);
      items_sent++;
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 9) < 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.beats_due.size() != 0 || req_stall !== 1'b0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(logic [CFG_W-1:0] total, logic [CFG_W-1:0] tmo, bit set_thr,
                            logic [CFG_W-1:0] thr);
      wait_idle();
      write_csr(CSR_TOTAL_PACKETS, total);
      write_csr(CSR_TIMEOUT_TICKS, tmo);
      if (set_thr) write_csr(CSR_INITIAL_THRESHOLD, thr);
      csr_write_en <= 1'b0;
      phases++;
   endtask

   task automatic random_item();
      int pick;
      int unsigned hop;
      logic [SEQ_W-1:0] an;
      logic af, nf;
      pick = $urandom_range(0, 99);
      an = SEQ_W'($urandom);
      af = 1'($urandom);
      nf = 1'($urandom);
      if (pick < 42) begin
         send_req(OP_TICK, an, af, nf);
      end else if (pick < 78) begin
         send_req(OP_ACK, SEQ_W'(sb.base + 1), 1'b1, 1'b0);
      end else if (pick < 87) begin
         // a burst of repeats is what sets the duplicate flag
         repeat (3) begin
            send_req(OP_ACK, SEQ_W'(sb.prev_ack), 1'b1, $urandom_range(0, 3) == 0);
            sender_gap();
         end
      end else if (pick < 92) begin
         hop = sb.base + $urandom_range(2, 16);
         send_req(OP_ACK, (hop > 16'hFFFF) ? 16'hFFFF : SEQ_W'(hop), 1'b1, 1'b0);
      end else begin
         send_req(OP_ACK, an, af, nf);
      end
   endtask

   initial begin
      int target, len, sel;
      int unsigned t;
      logic [CFG_W-1:0] total, tmo;
      bit wide_done;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      req_ack_number = '0;
      req_ack_flag = 1'b0;
      req_nak_flag = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_TOTAL_PACKETS;
      csr_wdata = '0;
      quiet = 1'b0;
      hold_req = 1'b0;
      items_sent = 0;
      phases = 0;
      wide_done = 1'b0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty transfer: status beats only, threshold loads while nothing sent
      configure(16'd0, 16'd500, 1'b1, 16'd1);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'hFFFF, 1'b1, 1'b1);

      configure(16'd20, 16'd1, 1'b1, 16'hFFFF);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd1, 1'b1, 1'b0);
      sender_gap();
      send_req(OP_TICK, 16'hFFFF, 1'b1, 1'b1);
      repeat (3) send_req(OP_ACK, 16'd1, 1'b1, 1'b0);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      // oldest timer runs out after duplicates: window from threshold, capped
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd2, 1'b1, 1'b1);
      send_req(OP_ACK, 16'd2, 1'b0, 1'b0);
      sender_gap();
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd2, 1'b1, 1'b0);
      // jump past the end saturates at total_packets
      send_req(OP_ACK, 16'hFFFF, 1'b1, 1'b0);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd21, 1'b1, 1'b0);

      configure(16'd100, 16'hFFFF, 1'b0, 16'd0);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd21, 1'b1, 1'b0);
      sender_gap();
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd0, 1'b0, 1'b0);
      send_req(OP_ACK, 16'd30, 1'b1, 1'b0);
      send_req(OP_TICK, 16'd0, 1'b0, 1'b0);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         sel = $urandom_range(0, 11);
         if (sel == 0) begin
            total = '0;
         end else if (sel == 1 && !wide_done) begin
            total = 16'hFFFF;
            wide_done = 1'b1;
         end else begin
            t = sb.base + $urandom_range(4, 48);
            total = (t > 16'hFFFF) ? 16'hFFFF : CFG_W'(t);
         end
         sel = $urandom_range(0, 7);
         if (sel == 0) tmo = 16'hFFFF;
         else if (sel == 1) tmo = 16'd1;
         else tmo = CFG_W'($urandom_range(2, 8));
         configure(total, tmo, $urandom_range(0, 2) == 0, CFG_W'($urandom_range(1, 65535)));
         if (phases == 4) hold_req = 1'b1;
         if (items_sent + 30 >= target) quiet = 1'b1;
         len = $urandom_range(12, 28);
         repeat (len) begin
            random_item();
            sender_gap();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d req beats (%0d ticks, %0d acks), %0d rsp beats, %0d settings",
               items_sent, sb.n_ticks, sb.n_acks, sb.n_beats, phases);
      $display("%0d new sends, %0d resends over %0d timeouts, longest run %0d beats",
               sb.n_new, sb.n_resends, sb.n_timeouts, sb.longest_run);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
